// ----- hdl/sdpser_pkg.sv -----
package sdpser_pkg;

  // Widths of the stream ports.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CAP_W      = 16;

  // Default depth of the queue between the classifier and the byte emitter.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Position of the written and status flags within out_tuser.
  localparam int unsigned OUT_USER_WRITTEN = 0;
  localparam int unsigned OUT_USER_STATUS  = 1;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'hffff;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  // Element type codes that have special cases.
  localparam logic [4:0] TYPE_NIL  = 5'd0;
  localparam logic [4:0] TYPE_BOOL = 5'd5;
  localparam logic [4:0] NUM_TYPES = 5'd9;

  // Size descriptors that add length bytes.
  localparam logic [2:0] DESC_LEN1 = 3'd5;
  localparam logic [2:0] DESC_LEN2 = 3'd6;
  localparam logic [2:0] DESC_LEN4 = 3'd7;

  localparam logic [7:0] FIXED_MASK = 8'h1f;
  localparam logic [7:0] VAR_MASK   = 8'he0;

  // Valid-size bitmap per element type: bits 0..4 are fixed sizes of 1, 2, 4, 8 and
  // 16 bytes, bits 5..7 are one, two or four additional length bytes.
  localparam logic [7:0] VALID_SIZES [0:8] = '{
    8'h00, 8'h1f, 8'h1f, 8'h16, 8'he0, 8'h01, 8'he0, 8'he0, 8'he0
  };

  typedef enum logic [1:0] {
    OP_EMIT    = 2'd0,
    OP_ERROR   = 2'd1,
    OP_RESTART = 2'd2
  } cmd_op_t;

  // One queued command: up to five bytes, byte 0 in the lowest bits.
  typedef struct packed {
    cmd_op_t     op;
    logic [39:0] bytes;
    logic [2:0]  last_idx;
  } cmd_t;

endpackage

// ----- hdl/sdp_data_element_serializer.sv -----
// SDP data element serializer. Input items arrive on the in_ stream with their kind in
// in_tuser: an element header (type and data size) is turned into the type/descriptor
// byte followed by zero, one, two or four big-endian length bytes; a payload item passes
// its byte straight through; a restart empties the buffer count and gives no result;
// kind 3 is discarded. Every result byte leaves on the out_ stream, flagged written when
// the fill count was below the buffer capacity at that moment (the count then advances)
// and dropped otherwise; out_tlast marks the final byte of an input item. A header whose
// type or size is not permitted yields a single result with status set, byte zero and
// written clear. A classifier accepts an item per cycle while the command queue has
// room; the emitter behind it sends one byte per cycle while the receiver takes them,
// so payload items sustain one item per cycle, a header gives one, two, three or five
// result bytes and a restart gives no output. The queue depth (QUEUE_DEPTH) sets
// how far input can run ahead of the output. The capacity register is written through
// cfg_we and cfg_wdata, and should be changed only while the block is idle.
module sdp_data_element_serializer #(
  parameter int unsigned QUEUE_DEPTH = sdpser_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration: buffer_capacity.
  input  logic                               cfg_we,
  input  logic [sdpser_pkg::CAP_W-1:0]       cfg_wdata,
  // Input items.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata: element_type [4:0], data_size [36:5], data_byte [44:37], zero [47:45].
  input  logic [sdpser_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: kind [1:0].
  input  logic [sdpser_pkg::IN_USER_W-1:0]   in_tuser,
  // Result items.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata: out_byte [7:0].
  output logic [sdpser_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: written [0], status [1].
  output logic [sdpser_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                               out_tlast
);

  localparam int unsigned CMD_W = $bits(sdpser_pkg::cmd_t);

  sdpser_pkg::cmd_t q_wdata;
  sdpser_pkg::cmd_t q_rdata;
  logic [CMD_W-1:0] q_rdata_raw;
  logic             q_wr, q_rd, q_full, q_empty;

  // The classifier turns each input item other than kind 3 into one queued command.
  sdpser_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  sdpser_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata_raw),
    .empty   (q_empty)
  );

  assign q_rdata = sdpser_pkg::cmd_t'(q_rdata_raw);

  // The emitter walks the bytes of each command and keeps the fill count.
  sdpser_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hdl/sdpser_front.sv -----
module sdpser_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sdpser_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic [sdpser_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                                q_full,
  output logic                                q_wr,
  output sdpser_pkg::cmd_t                    q_wdata
);

  logic [4:0]  etype;
  logic [31:0] dsize;
  logic [7:0]  dbyte;
  logic [7:0]  vs;
  logic [2:0]  desc;
  logic        desc_ok;
  logic [7:0]  hdr;
  sdpser_pkg::kind_t kind;

  assign kind      = sdpser_pkg::kind_t'(in_tuser);
  assign etype     = in_tdata[4:0];
  assign dsize     = in_tdata[36:5];
  assign dbyte     = in_tdata[44:37];
  assign in_tready = !q_full;
  assign q_wr      = in_tvalid && !q_full && (kind != sdpser_pkg::KIND_UNUSED);
  assign hdr       = {etype, desc};

  // Size descriptor selection from the valid-size table.
  always_comb begin
    vs      = '0;
    desc    = '0;
    desc_ok = 1'b0;
    if (etype < sdpser_pkg::NUM_TYPES) begin
      vs = sdpser_pkg::VALID_SIZES[etype[3:0]];
      if ((etype == sdpser_pkg::TYPE_BOOL && dsize == 32'd1) ||
          (etype == sdpser_pkg::TYPE_NIL && dsize == 32'd0)) begin
        desc_ok = 1'b1;
      end else begin
        if ((vs & sdpser_pkg::FIXED_MASK) != 8'd0 && dsize != 32'd0) begin
          for (int i = 0; i < 5; i++) begin
            if (vs[i] && dsize == (32'd1 << i)) begin
              desc    = 3'(i);
              desc_ok = 1'b1;
            end
          end
        end
        if (!desc_ok && (vs & sdpser_pkg::VAR_MASK) != 8'd0) begin
          priority if (dsize <= 32'h0000_00ff && vs[5]) begin
            desc    = sdpser_pkg::DESC_LEN1;
            desc_ok = 1'b1;
          end else if (dsize <= 32'h0000_ffff && vs[6]) begin
            desc    = sdpser_pkg::DESC_LEN2;
            desc_ok = 1'b1;
          end else if (vs[7]) begin
            desc    = sdpser_pkg::DESC_LEN4;
            desc_ok = 1'b1;
          end else begin
            desc_ok = 1'b0;
          end
        end
      end
    end
  end

  // Command build: length bytes follow the header byte most significant first.
  always_comb begin
    q_wdata.op       = sdpser_pkg::OP_EMIT;
    q_wdata.bytes    = '0;
    q_wdata.last_idx = '0;
    unique case (kind)
      sdpser_pkg::KIND_HEADER: begin
        if (!desc_ok) begin
          q_wdata.op = sdpser_pkg::OP_ERROR;
        end else if (desc == sdpser_pkg::DESC_LEN4) begin
          q_wdata.bytes    = {dsize[7:0], dsize[15:8], dsize[23:16], dsize[31:24], hdr};
          q_wdata.last_idx = 3'd4;
        end else if (desc == sdpser_pkg::DESC_LEN2) begin
          q_wdata.bytes    = {16'd0, dsize[7:0], dsize[15:8], hdr};
          q_wdata.last_idx = 3'd2;
        end else if (desc == sdpser_pkg::DESC_LEN1) begin
          q_wdata.bytes    = {24'd0, dsize[7:0], hdr};
          q_wdata.last_idx = 3'd1;
        end else begin
          q_wdata.bytes    = {32'd0, hdr};
        end
      end
      sdpser_pkg::KIND_PAYLOAD: begin
        q_wdata.bytes = {32'd0, dbyte};
      end
      sdpser_pkg::KIND_RESTART: begin
        q_wdata.op = sdpser_pkg::OP_RESTART;
      end
      sdpser_pkg::KIND_UNUSED: begin
        q_wdata.op = sdpser_pkg::OP_EMIT;
      end
      default: begin
        q_wdata.op = sdpser_pkg::OP_EMIT;
      end
    endcase
  end

endmodule

// ----- hdl/sdpser_fifo.sv -----
module sdpser_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/sdpser_back.sv -----
module sdpser_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [sdpser_pkg::CAP_W-1:0]       cfg_wdata,
  input  logic                               q_empty,
  input  sdpser_pkg::cmd_t                   q_rdata,
  output logic                               q_rd,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sdpser_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [sdpser_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                               out_tlast
);

  logic [sdpser_pkg::CAP_W-1:0] cap_r;
  logic [sdpser_pkg::CAP_W-1:0] fill_r, fill_nxt;
  logic [2:0]                   idx_r, idx_nxt;
  logic                         valid_r, valid_nxt;
  logic [7:0]                   byte_r, byte_nxt;
  logic                         last_r, last_nxt;
  logic                         written_r, written_nxt;
  logic                         status_r, status_nxt;
  logic                         out_ld;
  logic                         fits;
  logic                         at_last;

  assign out_ld  = !valid_r || out_tready;
  assign fits    = fill_r < cap_r;
  assign at_last = (idx_r == q_rdata.last_idx);

  always_comb begin
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    valid_nxt   = valid_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    written_nxt = written_r;
    status_nxt  = status_r;
    q_rd        = 1'b0;
    if (out_ld) begin
      valid_nxt = 1'b0;
    end
    if (!q_empty) begin
      unique case (q_rdata.op)
        sdpser_pkg::OP_EMIT: begin
          if (out_ld) begin
            valid_nxt   = 1'b1;
            byte_nxt    = q_rdata.bytes[idx_r*8 +: 8];
            last_nxt    = at_last;
            written_nxt = fits;
            status_nxt  = 1'b0;
            if (fits) begin
              fill_nxt = fill_r + 1'b1;
            end
            idx_nxt = at_last ? '0 : idx_r + 1'b1;
            q_rd    = at_last;
          end
        end
        sdpser_pkg::OP_ERROR: begin
          if (out_ld) begin
            valid_nxt   = 1'b1;
            byte_nxt    = '0;
            last_nxt    = 1'b1;
            written_nxt = 1'b0;
            status_nxt  = 1'b1;
            q_rd        = 1'b1;
          end
        end
        sdpser_pkg::OP_RESTART: begin
          fill_nxt = '0;
          q_rd     = 1'b1;
        end
        default: begin
          q_rd = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= sdpser_pkg::CAP_RESET;
      fill_r  <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    written_r <= written_nxt;
    status_r  <= status_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  always_comb begin
    out_tuser = '0;
    out_tuser[sdpser_pkg::OUT_USER_WRITTEN] = written_r;
    out_tuser[sdpser_pkg::OUT_USER_STATUS]  = status_r;
  end

endmodule

// ----- hdl/sdpser_checker.sv -----
module sdpser_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_we,
  input logic [sdpser_pkg::CAP_W-1:0]       cfg_wdata,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [sdpser_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [sdpser_pkg::OUT_USER_W-1:0]  out_tuser,
  input logic                               out_tlast
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // An error result is a single dropped zero byte.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[sdpser_pkg::OUT_USER_STATUS] |->
      out_tlast && !out_tuser[sdpser_pkg::OUT_USER_WRITTEN] && out_tdata == '0)
    else $error("malformed error result");

  // Straight after reset nothing is pending and input is taken.
  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // With a zero capacity written while idle, a result straight after the write is not stored.
  a_cap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_wdata == '0 && !in_tvalid && !out_tvalid ##1
      out_tvalid |-> !out_tuser[sdpser_pkg::OUT_USER_WRITTEN])
    else $error("byte stored with zero capacity");

endmodule

bind sdp_data_element_serializer sdpser_checker u_sdpser_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Element type codes that the package does not name.
  localparam logic [4:0] TY_UINT = 5'd1;
  localparam logic [4:0] TY_SINT = 5'd2;
  localparam logic [4:0] TY_UUID = 5'd3;
  localparam logic [4:0] TY_STR  = 5'd4;
  localparam logic [4:0] TY_SEQ  = 5'd6;
  localparam logic [4:0] TY_ALT  = 5'd7;
  localparam logic [4:0] TY_URL  = 5'd8;

  // Permitted sizes per type: bits 0..4 are fixed sizes of 1, 2, 4, 8 and 16 bytes,
  // bits 5..7 mean one, two or four length bytes follow the header byte.
  localparam logic [7:0] SZ_FIXED_ALL = 8'h1f;
  localparam logic [7:0] SZ_UUID      = 8'h16;
  localparam logic [7:0] SZ_LEN       = 8'he0;

  // Cycles with no handshake on either side before the run is declared hung. The
  // longest deliberate silence is the receiver's long hold-off of HOLD_CYCLES.
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last expected byte for restarts still travelling through
  // the command queue.
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned ITEMS_PER_STEP = 25;

  // One result byte as it should leave the block.
  typedef struct packed {
    logic [7:0] val;
    logic       wr;
    logic       lst;
    logic       st;
  } byte_res_t;

  // One input item, with an optional hand-written expectation for its first result
  // byte and the number of bytes it produces.
  typedef struct packed {
    sdpser_pkg::kind_t kind;
    logic [4:0]        et;
    logic [31:0]       sz;
    logic [7:0]        db;
    logic              chk;
    logic [2:0]        n;
    logic [7:0]        b0;
    logic              wr;
    logic              st;
  } item_row_t;

  logic                              clk;
  logic                              rst_n      = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic [sdpser_pkg::CAP_W-1:0]      cfg_wdata  = '0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  // in_tdata: element_type [4:0], data_size [36:5], data_byte [44:37], zero [47:45].
  logic [sdpser_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  // in_tuser: kind [1:0].
  logic [sdpser_pkg::IN_USER_W-1:0]  in_tuser   = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // out_tdata: out_byte [7:0].
  logic [sdpser_pkg::OUT_DATA_W-1:0] out_tdata;
  // out_tuser: written [0], status [1].
  logic [sdpser_pkg::OUT_USER_W-1:0] out_tuser;
  logic                              out_tlast;

  // Row currently offered, so that the checker can pick up a hand-written expectation.
  item_row_t cur_row = '0;

  // Predictor state: the byte count held in the buffer and the capacity register.
  logic [sdpser_pkg::CAP_W-1:0] buf_fill;
  logic [sdpser_pkg::CAP_W-1:0] buf_cap;
  byte_res_t                    enc_out [0:4];
  byte_res_t                    pending_bytes [$];

  int unsigned mismatches  = 0;
  int unsigned items_done  = 0;
  int unsigned burst_left  = 0;
  int unsigned hold_asked  = 0;

  sdp_data_element_serializer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Directed items, sent straight after reset with the capacity still at its reset
  // value, so every non-error byte is written. Header bytes are type<<3 | descriptor.
  item_row_t dir_tab [0:24] = '{
    // Nil takes only size 0 and bool only size 1, both with descriptor 0.
    '{sdpser_pkg::KIND_HEADER, sdpser_pkg::TYPE_NIL, 32'd0, 8'hff, 1'b1, 3'd1, 8'h00, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, sdpser_pkg::TYPE_BOOL, 32'd1, 8'h00, 1'b1, 3'd1, 8'h28, 1'b1, 1'b0},
    // Fixed sizes at both ends of the range.
    '{sdpser_pkg::KIND_HEADER, TY_UINT, 32'd1,        8'hff, 1'b1, 3'd1, 8'h08, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_UINT, 32'd16,       8'h00, 1'b1, 3'd1, 8'h0c, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_SINT, 32'd8,        8'hff, 1'b1, 3'd1, 8'h13, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_UUID, 32'd2,        8'h00, 1'b1, 3'd1, 8'h19, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_UUID, 32'd16,       8'hff, 1'b1, 3'd1, 8'h1c, 1'b1, 1'b0},
    // Length-prefixed types at the edges of the one, two and four byte forms.
    '{sdpser_pkg::KIND_HEADER, TY_STR,  32'd0,        8'h00, 1'b1, 3'd2, 8'h25, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_STR,  32'd255,      8'hff, 1'b1, 3'd2, 8'h25, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_STR,  32'd256,      8'h00, 1'b1, 3'd3, 8'h26, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_SEQ,  32'd65535,    8'hff, 1'b1, 3'd3, 8'h36, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_ALT,  32'd65536,    8'h00, 1'b1, 3'd5, 8'h3f, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_HEADER, TY_URL,  32'hffffffff, 8'hff, 1'b1, 3'd5, 8'h47, 1'b1, 1'b0},
    // Sizes the type does not permit, zero for a fixed type, and unknown types.
    '{sdpser_pkg::KIND_HEADER, TY_UUID, 32'd8,        8'h00, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    '{sdpser_pkg::KIND_HEADER, sdpser_pkg::TYPE_NIL, 32'd1, 8'hff, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    '{sdpser_pkg::KIND_HEADER, sdpser_pkg::TYPE_BOOL, 32'd0, 8'h00, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    '{sdpser_pkg::KIND_HEADER, TY_UINT, 32'd0,        8'hff, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    '{sdpser_pkg::KIND_HEADER, TY_SINT, 32'd3,        8'h00, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    '{sdpser_pkg::KIND_HEADER, 5'd9,    32'd1,        8'hff, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    '{sdpser_pkg::KIND_HEADER, 5'd31,   32'hffffffff, 8'h00, 1'b1, 3'd1, 8'h00, 1'b0, 1'b1},
    // Payload bytes pass through; the header fields they carry are ignored.
    '{sdpser_pkg::KIND_PAYLOAD, 5'd31,  32'hffffffff, 8'h00, 1'b1, 3'd1, 8'h00, 1'b1, 1'b0},
    '{sdpser_pkg::KIND_PAYLOAD, 5'd0,   32'd0,        8'hff, 1'b1, 3'd1, 8'hff, 1'b1, 1'b0},
    // The unused kind and a restart give nothing; the byte after a restart is written.
    '{sdpser_pkg::KIND_UNUSED,  5'd31,  32'hffffffff, 8'hff, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
    '{sdpser_pkg::KIND_RESTART, 5'd31,  32'hffffffff, 8'hff, 1'b1, 3'd0, 8'h00, 1'b0, 1'b0},
    '{sdpser_pkg::KIND_PAYLOAD, 5'd10,  32'h5a5a5a5a, 8'h5a, 1'b1, 3'd1, 8'h5a, 1'b1, 1'b0}
  };

  // Capacities visited in turn. The full-size setting is followed by a small one with
  // no restart in between, so the count may start above the capacity and then every
  // byte drops until the next restart. The last entry is replaced by a random value.
  logic [sdpser_pkg::CAP_W-1:0] cap_plan [0:7] = '{
    16'd0, 16'd1, 16'd5, 16'hffff, 16'd3, 16'd2, 16'd17, 16'd9
  };

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // Returns the size descriptor for a header, or -1 when the type and size do not go
  // together.
  function automatic int choose_descriptor(input logic [4:0] et, input logic [31:0] sz);
    logic [7:0] ok;
    int         i;
    if (et == sdpser_pkg::TYPE_NIL && sz == 32'd0) return 0;
    if (et == sdpser_pkg::TYPE_BOOL && sz == 32'd1) return 0;
    case (et)
      TY_UINT, TY_SINT:               ok = SZ_FIXED_ALL;
      TY_UUID:                        ok = SZ_UUID;
      TY_STR, TY_SEQ, TY_ALT, TY_URL: ok = SZ_LEN;
      default:                        ok = 8'h00;
    endcase
    for (i = 0; i < 5; i++)
      if (ok[i] && sz == (32'd1 << i)) return i;
    if (ok[5] && sz <= 32'hff) return int'(sdpser_pkg::DESC_LEN1);
    if (ok[6] && sz <= 32'hffff) return int'(sdpser_pkg::DESC_LEN2);
    if (ok[7]) return int'(sdpser_pkg::DESC_LEN4);
    return -1;
  endfunction

  // Works out the bytes one accepted item produces into enc_out and returns how many.
  // The buffer count advances for each byte that still fits.
  function automatic int encode_item(input sdpser_pkg::kind_t k, input logic [4:0] et,
                                     input logic [31:0] sz, input logic [7:0] db);
    logic [7:0] hb [0:4];
    int         desc;
    int         n;
    int         i;
    logic       fits;
    case (k)
      sdpser_pkg::KIND_PAYLOAD: begin
        hb[0] = db;
        n = 1;
      end
      sdpser_pkg::KIND_RESTART: begin
        buf_fill = '0;
        return 0;
      end
      sdpser_pkg::KIND_HEADER: begin
        desc = choose_descriptor(et, sz);
        if (desc < 0) begin
          // A refused header gives a single flagged byte and leaves the count alone.
          enc_out[0].val = 8'h00;
          enc_out[0].wr  = 1'b0;
          enc_out[0].lst = 1'b1;
          enc_out[0].st  = 1'b1;
          return 1;
        end
        hb[0] = {et, desc[2:0]};
        if (desc == int'(sdpser_pkg::DESC_LEN4)) begin
          hb[1] = sz[31:24];
          hb[2] = sz[23:16];
          hb[3] = sz[15:8];
          hb[4] = sz[7:0];
          n = 5;
        end else if (desc == int'(sdpser_pkg::DESC_LEN2)) begin
          hb[1] = sz[15:8];
          hb[2] = sz[7:0];
          n = 3;
        end else if (desc == int'(sdpser_pkg::DESC_LEN1)) begin
          hb[1] = sz[7:0];
          n = 2;
        end else begin
          n = 1;
        end
      end
      default: return 0;
    endcase
    for (i = 0; i < n; i++) begin
      fits = (buf_fill < buf_cap);
      if (fits) buf_fill = buf_fill + 1'b1;
      enc_out[i].val = hb[i];
      enc_out[i].wr  = fits;
      enc_out[i].lst = (i == n - 1);
      enc_out[i].st  = 1'b0;
    end
    return n;
  endfunction

  // Checker. Everything is sampled at the rising edge, before the block's registers
  // move, so it sees exactly what the block saw. Accepted input items are turned into
  // expected bytes first, then any accepted output byte is compared with the oldest.
  always @(posedge clk) begin
    byte_res_t want;
    int        n;
    int        i;
    if (!rst_n) begin
      buf_fill = '0;
      buf_cap  = sdpser_pkg::CAP_RESET;
      pending_bytes.delete();
    end else begin
      if (cfg_we) buf_cap = cfg_wdata;
      if (in_tvalid && in_tready) begin
        n = encode_item(sdpser_pkg::kind_t'(in_tuser), in_tdata[4:0], in_tdata[36:5],
                        in_tdata[44:37]);
        // Directed rows carry their first byte and byte count written out by hand.
        if (cur_row.chk) begin
          n = int'(cur_row.n);
          enc_out[0].val = cur_row.b0;
          enc_out[0].wr  = cur_row.wr;
          enc_out[0].st  = cur_row.st;
          enc_out[0].lst = (n == 1);
        end
        for (i = 0; i < n; i++) pending_bytes.push_back(enc_out[i]);
      end
      if (out_tvalid && out_tready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("result byte with nothing expected", 0, 32'(out_tdata));
        end else begin
          want = pending_bytes.pop_front();
          if (out_tdata !== want.val)
            report_mismatch("out_byte", 32'(want.val), 32'(out_tdata));
          if (out_tuser[sdpser_pkg::OUT_USER_WRITTEN] !== want.wr)
            report_mismatch("written", 32'(want.wr),
                            32'(out_tuser[sdpser_pkg::OUT_USER_WRITTEN]));
          if (out_tuser[sdpser_pkg::OUT_USER_STATUS] !== want.st)
            report_mismatch("status", 32'(want.st),
                            32'(out_tuser[sdpser_pkg::OUT_USER_STATUS]));
          if (out_tlast !== want.lst)
            report_mismatch("last", 32'(want.lst), 32'(out_tlast));
        end
      end
    end
  end

  // Receiver. It switches between a few stall patterns every so often, including
  // stretches where it never stalls. When asked, it holds off for a long stretch so
  // the command queue fills and the block pushes back on its input.
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_age  = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    stall_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (stall_age == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_age  = $urandom_range(20, 120);
      end else begin
        stall_age--;
      end
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        2:       out_tready <= (stall_tick % 3 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Offers one item and waits for it to be taken. The sender runs in bursts: between
  // bursts it drops tvalid for a random gap, sometimes a long one, sometimes none.
  task automatic send_item(input item_row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0:       gap = $urandom_range(8, 24);
        1, 2, 3: gap = $urandom_range(1, 4);
        default: gap = 0;
      endcase
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, r.db, r.sz, r.et};
    in_tuser  <= r.kind;
    cur_row   <= r;
    do @(posedge clk); while (!in_tready);
    if (r.kind != sdpser_pkg::KIND_UNUSED) items_done++;
  endtask

  function automatic item_row_t make_row(input sdpser_pkg::kind_t k, input logic [4:0] et,
                                         input logic [31:0] sz, input logic [7:0] db);
    item_row_t r;
    r      = '0;
    r.kind = k;
    r.et   = et;
    r.sz   = sz;
    r.db   = db;
    return r;
  endfunction

  // A well-formed element: a valid header followed by its payload bytes. Very long
  // elements are cut short after a few bytes, which the block does not mind.
  task automatic send_element();
    logic [4:0]  et;
    logic [31:0] sz;
    int unsigned plen;
    int unsigned i;
    et = 5'($urandom_range(0, 8));
    case (et)
      sdpser_pkg::TYPE_NIL:  sz = 32'd0;
      sdpser_pkg::TYPE_BOOL: sz = 32'd1;
      TY_UINT, TY_SINT:      sz = 32'd1 << $urandom_range(0, 4);
      TY_UUID: begin
        case ($urandom_range(0, 2))
          0:       sz = 32'd2;
          1:       sz = 32'd4;
          default: sz = 32'd16;
        endcase
      end
      default: begin
        case ($urandom_range(0, 9))
          0:       sz = $urandom_range(256, 65535);
          1:       sz = $urandom();
          2:       sz = $urandom_range(65536, 1 << 24);
          default: sz = $urandom_range(0, 6);
        endcase
      end
    endcase
    send_item(make_row(sdpser_pkg::KIND_HEADER, et, sz, 8'($urandom_range(0, 255))));
    plen = (sz > 32'd16) ? $urandom_range(0, 6) : sz;
    for (i = 0; i < plen; i++)
      send_item(make_row(sdpser_pkg::KIND_PAYLOAD, 5'($urandom_range(0, 31)), $urandom(),
                         8'($urandom_range(0, 255))));
  endtask

  // A header that is mostly refused: an unknown type, or a fixed-size type with an
  // arbitrary size.
  task automatic send_bad_header();
    logic [4:0]  et;
    logic [31:0] sz;
    if ($urandom_range(0, 1) == 1) begin
      et = 5'($urandom_range(9, 31));
      sz = $urandom();
    end else begin
      case ($urandom_range(0, 3))
        0:       et = sdpser_pkg::TYPE_NIL;
        1:       et = sdpser_pkg::TYPE_BOOL;
        2:       et = TY_UUID;
        default: et = 5'($urandom_range(1, 2));
      endcase
      sz = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 20) : $urandom();
    end
    send_item(make_row(sdpser_pkg::KIND_HEADER, et, sz, 8'($urandom_range(0, 255))));
  endtask

  // Random traffic until the given number of items that matter has been taken.
  task automatic run_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    goal = items_done + count;
    while (items_done < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_element();
      else if (pick < 80)
        send_item(make_row(sdpser_pkg::KIND_RESTART, 5'($urandom_range(0, 31)), $urandom(),
                           8'($urandom_range(0, 255))));
      else if (pick < 92)
        send_bad_header();
      else if (pick < 96)
        send_item(make_row(sdpser_pkg::KIND_UNUSED, 5'($urandom_range(0, 31)), $urandom(),
                           8'($urandom_range(0, 255))));
      else
        send_item(make_row(sdpser_pkg::KIND_PAYLOAD, 5'($urandom_range(0, 31)), $urandom(),
                           8'($urandom_range(0, 255))));
    end
  endtask

  // Stops offering and waits until every expected byte has left the block, then
  // SETTLE_CYCLES more for restarts, which produce no byte.
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [sdpser_pkg::CAP_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Watchdog: a run that goes too long without any item moving on either side is hung.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Main sequence: reset, the directed table, then one random phase per capacity.
  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    cap_plan[7] = 16'($urandom_range(0, 40));
    for (i = 0; i < 8; i++) begin
      wait_drained();
      set_capacity(cap_plan[i]);
      run_traffic(ITEMS_PER_STEP);
      // Midway through some phases the receiver holds off for a long time while the
      // sender keeps going, and once the sender stops until everything has come out.
      if (i == 2 || i == 6) hold_asked++;
      if (i == 4) wait_drained();
      run_traffic(ITEMS_PER_STEP);
    end

    wait_drained();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
